FILE: design/bfpae_pkg.sv
// Shared types and constants for the best-fit buffer pool with age eviction.
// Holds the input and result word layouts, command and status codes, and the
// control and status bundles passed between the controller and the datapath.
`timescale 1ns / 1ps

package bfpae_pkg;

  localparam int SIZE_W   = 32;
  localparam int HANDLE_W = 5;
  localparam int SLOT_W   = 5;
  localparam int AGE_W    = 16;
  localparam int FRAME_W  = 32;

  // Command codes of an input word.
  localparam logic [1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  // Status codes of a result word.
  localparam logic [2:0] ST_REUSED   = 3'd0;
  localparam logic [2:0] ST_CREATED  = 3'd1;
  localparam logic [2:0] ST_RELEASED = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_EVICTED  = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  typedef struct packed {
    logic [1:0]          command;
    logic [SIZE_W-1:0]   size;
    logic [HANDLE_W-1:0] handle;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [2:0]        status;
    logic [SIZE_W-1:0] capacity;
    logic              last;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // latch the input word and restart the scan
    logic scan;    // run the slot scan pipeline
    logic look;    // read the memories at the release handle
    logic finish;  // commit the final update and emit the closing word
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // every slot has been read and evaluated
    logic out_free;   // the output register can take a word this cycle
  } dp_stat_t;

endpackage

FILE: design/bfpae_ctrl.sv
// Controller state machine of the buffer pool: sequences accept, scan or
// lookup, and the finishing step. Depends on bfpae_pkg for the command bundle.
`timescale 1ns / 1ps

module bfpae_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_command,
  output logic                  in_ready,
  input  bfpae_pkg::dp_stat_t   stat,
  output bfpae_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LOOK = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  // A new word is taken only when the previous one has been fully handled.
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Command decode toward the datapath.
  always_comb begin
    cmd.accept = accept;
    cmd.scan   = (state_r == S_SCAN);
    cmd.look   = (state_r == S_LOOK);
    cmd.finish = (state_r == S_FIN);
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_command == bfpae_pkg::CMD_RELEASE) ? S_LOOK : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = S_FIN;
        end
      end
      S_LOOK: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/bfpae_dp.sv
// Datapath of the buffer pool: slot flags, capacity and stamp memories, the
// scan pipeline, frame and age registers, and the output register.
// Depends on bfpae_pkg for word layouts, codes and the control bundles.
`timescale 1ns / 1ps

module bfpae_dp #(
  parameter int SLOTS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bfpae_pkg::in_word_t          in_data,
  input  logic                         cfg_valid,
  input  logic [bfpae_pkg::AGE_W-1:0]  cfg_data,
  input  bfpae_pkg::ctrl_cmd_t         cmd,
  output bfpae_pkg::dp_stat_t          stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bfpae_pkg::out_word_t         out_data
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] CNT_END = CW'(SLOTS);

  // Latched input word.
  logic [1:0]                       op_r;
  logic [bfpae_pkg::SIZE_W-1:0]     size_r;
  logic [bfpae_pkg::HANDLE_W-1:0]   handle_r;

  // Frame, age and eviction limit.
  logic [bfpae_pkg::FRAME_W-1:0]    frame_r;
  logic [bfpae_pkg::AGE_W-1:0]      age_r;
  logic [bfpae_pkg::FRAME_W-1:0]    limit_r;
  logic                             evict_ok_r;

  // Slot flags.
  logic [SLOTS-1:0]                 exists_r;
  logic [SLOTS-1:0]                 exists_nxt;
  logic [SLOTS-1:0]                 in_use_r;
  logic [SLOTS-1:0]                 in_use_nxt;

  // Capacity and stamp memories with registered read data.
  logic [bfpae_pkg::SIZE_W-1:0]     cap_mem   [SLOTS];
  logic [bfpae_pkg::FRAME_W-1:0]    stamp_mem [SLOTS];
  logic [bfpae_pkg::SIZE_W-1:0]     cap_q_r;
  logic [bfpae_pkg::FRAME_W-1:0]    stamp_q_r;

  // Scan pipeline.
  logic [CW-1:0]                    rd_cnt_r;
  logic                             ev_vld_r;
  logic [IW-1:0]                    ev_idx_r;
  logic                             issue;
  logic                             rd_en;
  logic [IW-1:0]                    rd_addr;
  logic                             stall;
  logic                             ev_go;

  // Best-fit and first-empty trackers.
  logic                             best_vld_r;
  logic [IW-1:0]                    best_idx_r;
  logic [bfpae_pkg::SIZE_W-1:0]     best_cap_r;
  logic                             empty_vld_r;
  logic [IW-1:0]                    empty_idx_r;

  // Evaluation and finishing signals.
  logic                             is_acq;
  logic                             is_sweep;
  logic                             sweep_all;
  logic                             ev_exists;
  logic                             ev_used;
  logic                             fits;
  logic                             new_empty;
  logic                             evict_hit;
  logic                             h_in_range;
  logic [IW-1:0]                    h_idx;
  logic                             rel_ok;
  logic                             fin_go;
  logic                             cap_we;
  logic                             stamp_we;
  logic [IW-1:0]                    wr_addr;

  // Output register.
  logic                             out_valid_r;
  bfpae_pkg::out_word_t             out_data_r;
  bfpae_pkg::out_word_t             fin_word;
  bfpae_pkg::out_word_t             ev_word;
  logic                             out_free;
  logic                             out_load;

  assign out_free = !out_valid_r || out_ready;
  assign is_acq    = (op_r == bfpae_pkg::CMD_ACQUIRE);
  assign sweep_all = (op_r == bfpae_pkg::CMD_CLEAR);
  assign is_sweep  = (op_r == bfpae_pkg::CMD_TICK) || sweep_all;

  // Latch the input word on accept.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_data.command;
      size_r   <= in_data.size;
      handle_r <= in_data.handle;
    end
  end

  // Frame counter and eviction age register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
      age_r   <= bfpae_pkg::AGE_W'(3);
    end else begin
      if (cmd.accept && in_data.command == bfpae_pkg::CMD_TICK) begin
        frame_r <= frame_r + 1'b1;
      end
      if (cfg_valid) begin
        age_r <= cfg_data;
      end
    end
  end

  // The limit is registered from the frame; the scan evaluates a slot only in
  // the cycle after its read, so the limit is current by then.
  always_ff @(posedge clk) begin
    limit_r    <= frame_r - bfpae_pkg::FRAME_W'(age_r);
    evict_ok_r <= frame_r >= bfpae_pkg::FRAME_W'(age_r);
  end

  // Evaluation of the slot whose memory data is in the read registers.
  assign ev_exists = exists_r[ev_idx_r];
  assign ev_used   = in_use_r[ev_idx_r];
  assign fits      = ev_exists && !ev_used && (cap_q_r >= size_r) &&
                     (!best_vld_r || (cap_q_r < best_cap_r));
  assign new_empty = !ev_exists && !empty_vld_r;
  assign evict_hit = ev_vld_r && is_sweep && ev_exists && !ev_used &&
                     (sweep_all || (evict_ok_r && (stamp_q_r < limit_r)));
  assign stall     = evict_hit && !out_free;
  assign ev_go     = ev_vld_r && !stall;

  // Read address issue: the scan walks the slots, a release reads its handle.
  assign issue   = cmd.scan && (rd_cnt_r != CNT_END) && !stall;
  assign h_idx   = IW'(handle_r);
  assign rd_en   = issue || cmd.look;
  assign rd_addr = cmd.look ? h_idx : rd_cnt_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r <= CNT_END;
      ev_vld_r <= 1'b0;
    end else if (cmd.accept) begin
      rd_cnt_r <= '0;
      ev_vld_r <= 1'b0;
    end else if (!stall) begin
      if (issue) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
      ev_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      ev_idx_r <= rd_cnt_r[IW-1:0];
    end
  end

  // Best-fit and first-empty tracking during an acquire scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_vld_r  <= 1'b0;
      empty_vld_r <= 1'b0;
    end else if (cmd.accept) begin
      best_vld_r  <= 1'b0;
      empty_vld_r <= 1'b0;
    end else if (ev_go && is_acq) begin
      if (fits) begin
        best_vld_r <= 1'b1;
      end
      if (new_empty) begin
        empty_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_go && is_acq) begin
      if (fits) begin
        best_idx_r <= ev_idx_r;
        best_cap_r <= cap_q_r;
      end
      if (new_empty) begin
        empty_idx_r <= ev_idx_r;
      end
    end
  end

  // Release checks.
  assign h_in_range = (32'(handle_r) < 32'(SLOTS));
  assign rel_ok     = h_in_range && exists_r[h_idx] && in_use_r[h_idx];
  assign fin_go     = cmd.finish && out_free;

  // Slot flag updates: evictions during the scan, the commit at the finish.
  always_comb begin
    exists_nxt = exists_r;
    in_use_nxt = in_use_r;
    if (ev_go && evict_hit) begin
      exists_nxt[ev_idx_r] = 1'b0;
    end
    if (fin_go) begin
      if (is_acq) begin
        if (best_vld_r) begin
          in_use_nxt[best_idx_r] = 1'b1;
        end else if (empty_vld_r) begin
          exists_nxt[empty_idx_r] = 1'b1;
          in_use_nxt[empty_idx_r] = 1'b1;
        end
      end else if (op_r == bfpae_pkg::CMD_RELEASE && rel_ok) begin
        in_use_nxt[h_idx] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exists_r <= '0;
      in_use_r <= '0;
    end else begin
      exists_r <= exists_nxt;
      in_use_r <= in_use_nxt;
    end
  end

  // Memory writes: capacity on creation, stamp on creation and release.
  assign cap_we   = fin_go && is_acq && !best_vld_r && empty_vld_r;
  assign stamp_we = cap_we ||
                    (fin_go && op_r == bfpae_pkg::CMD_RELEASE && rel_ok);
  assign wr_addr  = is_acq ? empty_idx_r : h_idx;

  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap_mem[wr_addr] <= size_r;
    end
    if (stamp_we) begin
      stamp_mem[wr_addr] <= frame_r;
    end
    if (rd_en) begin
      cap_q_r   <= cap_mem[rd_addr];
      stamp_q_r <= stamp_mem[rd_addr];
    end
  end

  // Closing word of the current command.
  always_comb begin
    fin_word.slot     = '0;
    fin_word.status   = bfpae_pkg::ST_DONE;
    fin_word.capacity = '0;
    fin_word.last     = 1'b1;
    unique case (op_r)
      bfpae_pkg::CMD_ACQUIRE: begin
        if (best_vld_r) begin
          fin_word.slot     = bfpae_pkg::SLOT_W'(best_idx_r);
          fin_word.status   = bfpae_pkg::ST_REUSED;
          fin_word.capacity = best_cap_r;
        end else if (empty_vld_r) begin
          fin_word.slot     = bfpae_pkg::SLOT_W'(empty_idx_r);
          fin_word.status   = bfpae_pkg::ST_CREATED;
          fin_word.capacity = size_r;
        end else begin
          fin_word.status   = bfpae_pkg::ST_FULL;
        end
      end
      bfpae_pkg::CMD_RELEASE: begin
        fin_word.slot = handle_r;
        if (rel_ok) begin
          fin_word.status   = bfpae_pkg::ST_RELEASED;
          fin_word.capacity = cap_q_r;
        end else begin
          fin_word.status   = bfpae_pkg::ST_UNKNOWN;
        end
      end
      default: begin
        fin_word.status = bfpae_pkg::ST_DONE;
      end
    endcase
  end

  // Word reporting one evicted slot.
  always_comb begin
    ev_word.slot     = bfpae_pkg::SLOT_W'(ev_idx_r);
    ev_word.status   = bfpae_pkg::ST_EVICTED;
    ev_word.capacity = cap_q_r;
    ev_word.last     = 1'b0;
  end

  // Output register: loads when empty or while the receiver takes the previous word.
  assign out_load = (ev_go && evict_hit) || fin_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= fin_go ? fin_word : ev_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    stat.scan_done = (rd_cnt_r == CNT_END) && !ev_vld_r;
    stat.out_free  = out_free;
  end

  // A slot can only be in use if it exists.
  a_use_needs_exist: assert property (@(posedge clk) disable iff (!rst_n)
    (in_use_r & ~exists_r) == '0)
    else $error("slot marked in use without existing");

  // The scan counter never runs past the last slot.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_cnt_r <= CNT_END)
    else $error("scan counter beyond slot count");

  // An evicted slot no longer exists in the next cycle.
  a_evict_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_go && evict_hit) |=> !exists_r[$past(ev_idx_r)])
    else $error("evicted slot still exists");

  // The finishing step of a scanning command starts with the pipeline empty.
  a_fin_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && op_r != bfpae_pkg::CMD_RELEASE) |-> stat.scan_done)
    else $error("finish reached with scan still running");

endmodule

FILE: design/best_fit_pool_with_age_eviction_top.sv
// Top level of the best-fit buffer pool with age-based eviction.
// Instantiates bfpae_ctrl and bfpae_dp; depends on bfpae_pkg for word types.
//
// Input words (command, size, handle) arrive on in_valid/in_ready/in_data.
// Result words (slot, status, capacity, last) leave on out_valid/out_ready/
// out_data; last marks the final word of a command. The eviction age is
// written through cfg_valid/cfg_ready/cfg_data; write it only while idle,
// which the block does not enforce, as cfg_ready is always high.
// Acquire, frame tick and clear walk every slot once through a pipelined read
// of the capacity and stamp memories, evaluating each slot from the read
// registers; a finishing step then loads the closing word into the output
// register. A release reads only the entry at its handle before finishing.
// The controller takes one input word at a time, after the closing word of
// the last one is loaded; the memories have a single read port.
// rst_n (synchronous, active low) empties the table, zeroes the frame and
// sets the eviction age to 3. No clearing pass is needed.
// A result word waits in the output register until out_ready. Evictions do
// not slow the scan while the receiver keeps up; otherwise the scan, or the
// closing step, holds in place until the register frees.
`timescale 1ns / 1ps

module best_fit_pool_with_age_eviction_top #(
  parameter int SLOTS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bfpae_pkg::in_word_t          in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bfpae_pkg::out_word_t         out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bfpae_pkg::AGE_W-1:0]  cfg_data
);

  bfpae_pkg::ctrl_cmd_t cmd;
  bfpae_pkg::dp_stat_t  stat;
  logic                 cfg_we;

  // The age register takes a write in any cycle.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Sequencing of each input word.
  bfpae_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Slot table, scan pipeline and output register.
  bfpae_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
